// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside of reset.
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a trigger in one cycle is followed by a condition in the next cycle.
`define MHPQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/mhpq_pkg.sv =====
// Types and codes shared by the heap priority queue modules.
package mhpq_pkg;

  // Operation codes. Any code other than insert or extract reads the root only.
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // One request on the input channel.
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] score;
    logic [31:0] payload;
  } req_t;

  // One result on the output channel.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] top_score;
    logic [31:0] top_payload;
    logic [6:0]  entry_count;
  } rsp_t;

  // Commands from the controller to the datapath, one per controller state.
  typedef struct packed {
    logic latch_in;
    logic decide;
    logic take_root;
    logic up_rd;
    logic up_cmp;
    logic dn_rd;
    logic dn_cmp;
    logic load_out;
  } cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic is_insert;
    logic is_extract;
    logic score_zero;
    logic full;
    logic empty;
    logic last_gone;
    logic at_root;
    logic no_left;
    logic up_swap;
    logic dn_swap;
  } sts_t;

  // Controller states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_ROOT   = 8'b0000_0100,
    S_UP_RD  = 8'b0000_1000,
    S_UP_CMP = 8'b0001_0000,
    S_DN_RD  = 8'b0010_0000,
    S_DN_CMP = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_e;

endpackage

// ===== rtl/core/mhpq_ctrl.sv =====
// Sequencing state machine for the heap queue: accepts, sifts and hands off results.
`include "assert_macros.svh"

module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.is_insert) begin
          state_d = (sts_i.score_zero || sts_i.full) ? S_FIN : S_UP_RD;
        end else begin
          state_d = sts_i.empty ? S_FIN : S_ROOT;
        end
      end
      S_ROOT: begin
        cmd_o.take_root = 1'b1;
        state_d = (sts_i.is_extract && !sts_i.last_gone) ? S_DN_RD : S_FIN;
      end
      S_UP_RD: begin
        cmd_o.up_rd = 1'b1;
        state_d = sts_i.at_root ? S_FIN : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd_o.up_cmp = 1'b1;
        state_d = sts_i.up_swap ? S_UP_RD : S_FIN;
      end
      S_DN_RD: begin
        cmd_o.dn_rd = 1'b1;
        state_d = sts_i.no_left ? S_FIN : S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd_o.dn_cmp = 1'b1;
        state_d = sts_i.dn_swap ? S_DN_RD : S_FIN;
      end
      S_FIN: begin
        // Wait for the output register to be free, then load the result.
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output register holds a result until the consumer takes it.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.load_out) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  `MHPQ_ASSERT(load_slot_free_a, cmd_o.load_out |-> (!rsp_valid_q || rsp_ready_i),
    "result loaded over one that was not taken")
  `MHPQ_ASSERT_NEXT(accept_then_decide_a, req_valid_i && req_ready_o, cmd_o.decide,
    "accepted request not decoded in the next cycle")
  `MHPQ_ASSERT(root_after_decide_a, cmd_o.take_root |-> $past(cmd_o.decide),
    "root taken without a preceding decode")

endmodule

// ===== rtl/core/mhpq_dpath.sv =====
// Heap storage, sift position, entry count and result registers of the heap queue.
`include "assert_macros.svh"

module mhpq_dpath
  import mhpq_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int SCORE_WIDTH = 32,
  parameter int TAG_WIDTH   = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output rsp_t rsp_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = AW + 2;
  localparam int EW = SCORE_WIDTH + TAG_WIDTH;

  // Heap memory: each entry is the score above the tag.
  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic [EW-1:0] wr_data;
  logic          mem_we;

  logic [1:0]             op_q;
  logic [SCORE_WIDTH-1:0] score_q;
  logic [TAG_WIDTH-1:0]   tag_q;
  logic [EW-1:0]          cur_q;
  logic [AW-1:0]          pos_q;
  logic [CW-1:0]          count_q;
  logic [1:0]             res_status_q;
  logic [SCORE_WIDTH-1:0] res_score_q;
  logic [TAG_WIDTH-1:0]   res_tag_q;
  rsp_t                   out_q;

  logic [SCORE_WIDTH-1:0] in_score;
  logic [TAG_WIDTH-1:0]   in_tag;
  logic [31:0]            out_score, out_tag;
  logic [6:0]             out_count;

  logic                   is_insert, is_extract, full, empty, insert_ok;
  logic [AW-1:0]          parent, last_idx;
  logic [KW-1:0]          left, right, count_k;
  logic                   no_left, right_ok;
  logic [SCORE_WIDTH-1:0] cur_score, a_score, b_score, best_score;
  logic                   up_swap, pick_l, pick_r, dn_swap;
  logic [1:0]             decide_status;

  // Fit the fixed-width request fields to the stored widths.
  if (SCORE_WIDTH <= 32) begin : g_score_narrow
    assign in_score  = req_i.score[SCORE_WIDTH-1:0];
    assign out_score = {{(32 - SCORE_WIDTH){1'b0}}, res_score_q};
  end else begin : g_score_wide
    assign in_score  = {{(SCORE_WIDTH - 32){1'b0}}, req_i.score};
    assign out_score = res_score_q[31:0];
  end

  if (TAG_WIDTH <= 32) begin : g_tag_narrow
    assign in_tag  = req_i.payload[TAG_WIDTH-1:0];
    assign out_tag = {{(32 - TAG_WIDTH){1'b0}}, res_tag_q};
  end else begin : g_tag_wide
    assign in_tag  = {{(TAG_WIDTH - 32){1'b0}}, req_i.payload};
    assign out_tag = res_tag_q[31:0];
  end

  if (CW <= 7) begin : g_count_narrow
    assign out_count = {{(7 - CW){1'b0}}, count_q};
  end else begin : g_count_wide
    assign out_count = count_q[6:0];
  end

  // Operation decode and heap geometry around the current position.
  assign is_insert  = (op_q == OP_INSERT);
  assign is_extract = (op_q == OP_EXTRACT);
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);
  assign insert_ok  = is_insert && (score_q != '0) && !full;
  assign parent     = (pos_q - AW'(1)) >> 1;
  assign last_idx   = AW'(count_q - CW'(1));
  assign left       = {1'b0, pos_q, 1'b1};
  assign right      = left + KW'(1);
  assign count_k    = KW'(count_q);
  assign no_left    = (left >= count_k);
  assign right_ok   = (right < count_k);

  // Sift compares: up moves on strict greater, down prefers left, then right.
  assign cur_score  = cur_q[EW-1:TAG_WIDTH];
  assign a_score    = rd_a_q[EW-1:TAG_WIDTH];
  assign b_score    = rd_b_q[EW-1:TAG_WIDTH];
  assign up_swap    = (cur_score > a_score);
  assign pick_l     = (a_score > cur_score);
  assign best_score = pick_l ? a_score : cur_score;
  assign pick_r     = right_ok && (b_score > best_score);
  assign dn_swap    = pick_l || pick_r;

  always_comb begin
    if (is_insert) begin
      if (score_q == '0) begin
        decide_status = ST_IGNORED;
      end else if (full) begin
        decide_status = ST_FULL;
      end else begin
        decide_status = ST_OK;
      end
    end else begin
      decide_status = empty ? ST_EMPTY : ST_OK;
    end
  end

  // Memory addressing per command. The moving entry lives in cur_q until it settles.
  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = '0;
    mem_we    = 1'b0;
    wr_addr   = pos_q;
    wr_data   = cur_q;
    if (cmd_i.decide) begin
      rd_addr_b = last_idx;
    end
    if (cmd_i.up_rd) begin
      rd_addr_a = parent;
      mem_we    = (pos_q == '0);
    end
    if (cmd_i.up_cmp) begin
      mem_we = 1'b1;
      if (up_swap) begin
        wr_data = rd_a_q;
      end
    end
    if (cmd_i.dn_rd) begin
      rd_addr_a = left[AW-1:0];
      rd_addr_b = right[AW-1:0];
      mem_we    = no_left;
    end
    if (cmd_i.dn_cmp) begin
      mem_we = 1'b1;
      if (dn_swap) begin
        wr_data = pick_r ? rd_b_q : rd_a_q;
      end
    end
  end

  // Memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_a_q <= mem_q[rd_addr_a];
    rd_b_q <= mem_q[rd_addr_b];
  end

  // Entry count is the only control state here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.decide && insert_ok) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.take_root && is_extract) begin
      count_q <= count_q - CW'(1);
    end
  end

  // Request, sift and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q    <= req_i.operation;
      score_q <= in_score;
      tag_q   <= in_tag;
    end
    if (cmd_i.decide) begin
      res_status_q <= decide_status;
      res_score_q  <= '0;
      res_tag_q    <= '0;
      if (insert_ok) begin
        cur_q <= {score_q, tag_q};
        pos_q <= count_q[AW-1:0];
      end
    end
    if (cmd_i.take_root) begin
      res_score_q <= a_score;
      res_tag_q   <= rd_a_q[TAG_WIDTH-1:0];
      if (is_extract) begin
        cur_q <= rd_b_q;
        pos_q <= '0;
      end
    end
    if (cmd_i.up_cmp && up_swap) begin
      pos_q <= parent;
    end
    if (cmd_i.dn_cmp && dn_swap) begin
      pos_q <= pick_r ? right[AW-1:0] : left[AW-1:0];
    end
    if (cmd_i.load_out) begin
      out_q.status      <= res_status_q;
      out_q.top_score   <= out_score;
      out_q.top_payload <= out_tag;
      out_q.entry_count <= out_count;
    end
  end

  assign sts_o.is_insert  = is_insert;
  assign sts_o.is_extract = is_extract;
  assign sts_o.score_zero = (score_q == '0);
  assign sts_o.full       = full;
  assign sts_o.empty      = empty;
  assign sts_o.last_gone  = (count_q == CW'(1));
  assign sts_o.at_root    = (pos_q == '0);
  assign sts_o.no_left    = no_left;
  assign sts_o.up_swap    = up_swap;
  assign sts_o.dn_swap    = dn_swap;
  assign rsp_o            = out_q;

  `MHPQ_ASSERT(count_bound_a, count_q <= CW'(DEPTH),
    "entry count above heap depth")
  `MHPQ_ASSERT(write_in_heap_a, mem_we |-> (KW'(wr_addr) < count_k),
    "heap write outside the occupied entries")
  `MHPQ_ASSERT(down_has_left_a, cmd_i.dn_cmp |-> !no_left,
    "down compare without a left child")

endmodule

// ===== rtl/core/max_heap_priority_queue.sv =====
// Top level of the binary max-heap priority queue.
// Binary max-heap of DEPTH entries, each a score (unsigned Q16.16 by default) with a tag.
// Requests insert, extract the maximum or peek at it; every request gives exactly one
// result carrying a status, the root entry for extract and peek, and the entry count
// after the operation. One request is handled at a time, and a finished result waits
// in an output register while the next request is taken. The cost is set by the single
// heap memory, whose reads are registered: every level of a sift is a read state
// followed by a compare state that writes. An insert is decoded, then climbs level by
// level, ending on a read when it reaches the root; an extract is decoded, takes the
// root and sinks level by level, ending on a read at a leaf, or finishes after taking
// the root when it removes the only entry. A peek is decoded and reads the root; a
// rejected request is only decoded. The longest request is an insert that climbs from
// the deepest level to the root. A request finishes only once the previous result has
// left the output register, so a consumer that holds ready low adds its stall cycles
// to the request behind it.
// Heap storage has no reset and needs no clearing pass: only occupied entries are used.
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int SCORE_WIDTH = 32,
  parameter int TAG_WIDTH   = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // Controller: sequences each request through decode, sift and result hand-off.
  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: heap memory, count, sift position and result registers.
  mhpq_dpath #(
    .DEPTH       (DEPTH),
    .SCORE_WIDTH (SCORE_WIDTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

// ===== verif/tb_max_heap_priority_queue.sv =====
// Self-checking testbench for the max-heap priority queue with a built-in heap predictor.
module tb_max_heap_priority_queue;
  import mhpq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The package names only insert and extract; both remaining codes read the root.
  localparam logic [1:0] OP_PEEK     = 2'd2;
  localparam logic [1:0] OP_PEEK_ALT = 2'd3;
  localparam int         HEAP_DEPTH  = 64;
  localparam int         DRAIN_WAIT  = 24;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i       = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_o;

  // Shadow copy of the heap in heap order, updated as each request is accepted.
  logic [31:0] key_mem [HEAP_DEPTH];
  logic [31:0] tag_mem [HEAP_DEPTH];
  int unsigned heap_fill = 0;
  rsp_t        heap_replies_q [$];

  // Idle and stall rates in percent, changed per phase.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned stall_left    = 0;
  bit          calm_tail     = 1'b0;

  // Run bookkeeping.
  int unsigned mismatch_cnt = 0;
  int unsigned reply_cnt    = 0;
  int unsigned n_insert     = 0;
  int unsigned n_extract    = 0;
  int unsigned n_peek       = 0;
  int unsigned n_full       = 0;
  int unsigned n_empty      = 0;
  int unsigned n_ignored    = 0;
  int unsigned peak_fill    = 0;

  max_heap_priority_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  always #10 clk_i = ~clk_i;

  // Swap two heap slots, score and tag together.
  task automatic swap_slots(input int unsigned a, input int unsigned b);
    logic [31:0] k;
    logic [31:0] t;
    k = key_mem[a];
    t = tag_mem[a];
    key_mem[a] = key_mem[b];
    tag_mem[a] = tag_mem[b];
    key_mem[b] = k;
    tag_mem[b] = t;
  endtask

  // Apply one request to the shadow heap and return the reply it must produce.
  task automatic apply_heap_op(input req_t r, output rsp_t reply);
    int unsigned pos;
    int unsigned up;
    int unsigned best;
    int unsigned lc;
    int unsigned rc;
    bit          moving;
    reply = '0;
    reply.status = ST_OK;
    if (r.operation == OP_INSERT) begin
      n_insert++;
      if (r.score == '0) begin
        reply.status = ST_IGNORED;
        n_ignored++;
      end else if (heap_fill >= HEAP_DEPTH) begin
        reply.status = ST_FULL;
        n_full++;
      end else begin
        pos = heap_fill;
        key_mem[pos] = r.score;
        tag_mem[pos] = r.payload;
        moving = 1'b1;
        // Climb while strictly greater than the parent.
        while (moving && pos > 0) begin
          up = (pos - 1) / 2;
          if (key_mem[pos] > key_mem[up]) begin
            swap_slots(pos, up);
            pos = up;
          end else begin
            moving = 1'b0;
          end
        end
        heap_fill++;
      end
    end else begin
      if (r.operation == OP_EXTRACT) n_extract++;
      else n_peek++;
      if (heap_fill == 0) begin
        reply.status = ST_EMPTY;
        n_empty++;
      end else begin
        reply.top_score   = key_mem[0];
        reply.top_payload = tag_mem[0];
        if (r.operation == OP_EXTRACT) begin
          heap_fill--;
          key_mem[0] = key_mem[heap_fill];
          tag_mem[0] = tag_mem[heap_fill];
          pos = 0;
          moving = 1'b1;
          // Sink toward the strictly larger child, left child winning ties.
          while (moving) begin
            best = pos;
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc < heap_fill && key_mem[lc] > key_mem[best]) best = lc;
            if (rc < heap_fill && key_mem[rc] > key_mem[best]) best = rc;
            if (best == pos) begin
              moving = 1'b0;
            end else begin
              swap_slots(pos, best);
              pos = best;
            end
          end
        end
      end
    end
    reply.entry_count = 7'(heap_fill);
    if (heap_fill > peak_fill) peak_fill = heap_fill;
  endtask

  // Send one request, with an optional idle burst first, and record its reply.
  task automatic issue_request(input logic [1:0] op, input logic [31:0] score,
                               input logic [31:0] tag);
    req_t        item;
    rsp_t        reply;
    int unsigned gap;
    item.operation = op;
    item.score     = score;
    item.payload   = tag;
    gap = 0;
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
      gap = $urandom_range(11, 1);
    if (gap != 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= item;
    do @(posedge clk_i); while (!req_ready_o);
    apply_heap_op(item, reply);
    heap_replies_q.push_back(reply);
  endtask

  // Score mix: many small values for ties, some extremes, the rest anywhere.
  function automatic logic [31:0] pick_score(input bit allow_zero);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (allow_zero && roll < 5) return 32'd0;
    if (roll < 35) return 32'($urandom_range(6, 1));
    if (roll < 45) begin
      case ($urandom_range(3, 0))
        0: return 32'hFFFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0001_0000;
        default: return 32'd1;
      endcase
    end
    return ($urandom() == 0) ? 32'd1 : $urandom();
  endfunction

  // Operation choice from insert and extract weights; peeks use both peek codes.
  function automatic logic [1:0] pick_op(input int unsigned ins_pct, input int unsigned ext_pct);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < ins_pct) return OP_INSERT;
    if (roll < ins_pct + ext_pct) return OP_EXTRACT;
    return $urandom_range(1, 0) ? OP_PEEK_ALT : OP_PEEK;
  endfunction

  // Requests on an empty heap, both peek codes and a zero-score insert.
  task automatic test_empty_heap();
    issue_request(OP_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(OP_PEEK, 32'd0, 32'd0);
    issue_request(OP_PEEK_ALT, 32'd0, 32'd0);
    issue_request(OP_INSERT, 32'd0, 32'hFFFF_FFFF);
    issue_request(OP_EXTRACT, 32'd0, 32'd0);
  endtask

  // Extreme scores and tags, tied scores and ordering on extract.
  task automatic test_extremes_and_order();
    issue_request(OP_INSERT, 32'd1, 32'hFFFF_FFFF);
    issue_request(OP_INSERT, 32'hFFFF_FFFF, 32'd0);
    issue_request(OP_INSERT, 32'h0001_0000, 32'hA5A5_A5A5);
    issue_request(OP_INSERT, 32'h0001_0000, 32'h5A5A_5A5A);
    issue_request(OP_INSERT, 32'h0000_FFFF, 32'h1234_5678);
    issue_request(OP_PEEK, 32'd0, 32'd0);
    issue_request(OP_PEEK_ALT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(OP_INSERT, 32'd0, 32'h0BAD_F00D);
    repeat (5) issue_request(OP_EXTRACT, 32'd0, 32'd0);
    issue_request(OP_EXTRACT, 32'd0, 32'd0);
    issue_request(OP_PEEK, 32'd0, 32'd0);
  endtask

  // Fill to capacity, push against the limit, then drain to empty.
  task automatic test_full_heap();
    send_idle_pct = 15;
    stall_pct     = 15;
    while (heap_fill < HEAP_DEPTH)
      issue_request(OP_INSERT, pick_score(1'b0), $urandom());
    repeat (3) issue_request(OP_INSERT, pick_score(1'b0), $urandom());
    issue_request(OP_INSERT, 32'd0, $urandom());
    issue_request(OP_PEEK, 32'd0, 32'd0);
    while (heap_fill > 0) begin
      if ($urandom_range(7, 0) == 0) issue_request(pick_op(0, 0), $urandom(), $urandom());
      else issue_request(OP_EXTRACT, $urandom(), $urandom());
    end
    issue_request(OP_EXTRACT, 32'd0, 32'd0);
  endtask

  // Random phases that grow, drain or churn the heap with random contents.
  task automatic test_random_mix(input int unsigned target);
    int unsigned counted;
    int unsigned phase_len;
    int unsigned kind;
    logic [1:0]  op;
    logic [31:0] score;
    counted = 0;
    while (counted < target) begin
      kind      = $urandom_range(2, 0);
      phase_len = $urandom_range(40, 10);
      if (calm_tail) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end else begin
        case ($urandom_range(2, 0))
          0: send_idle_pct = 0;
          1: send_idle_pct = 15;
          default: send_idle_pct = 40;
        endcase
        case ($urandom_range(2, 0))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      repeat (phase_len) begin
        case (kind)
          0: op = pick_op(75, 15);
          1: op = pick_op(20, 65);
          default: op = pick_op(40, 35);
        endcase
        score = pick_score(1'b1);
        issue_request(op, score, $urandom());
        if (!(op == OP_INSERT && score == '0)) counted++;
      end
    end
  endtask

  // Reply stall pattern: random bursts with ready low, started at the phase's stall rate.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      rsp_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
      rsp_ready_i <= 1'b0;
      stall_left  <= $urandom_range(10, 0);
    end else begin
      rsp_ready_i <= 1'b1;
    end
  end

  // Compare every accepted reply against the oldest predicted one.
  always @(posedge clk_i) begin : reply_check
    rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      reply_cnt++;
      if (heap_replies_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("[%0t] reply with none outstanding: status=%0d score=%h tag=%h count=%0d",
                   $realtime, rsp_o.status, rsp_o.top_score, rsp_o.top_payload,
                   rsp_o.entry_count);
      end else begin
        want = heap_replies_q.pop_front();
        if (rsp_o.status !== want.status || rsp_o.top_score !== want.top_score ||
            rsp_o.top_payload !== want.top_payload ||
            rsp_o.entry_count !== want.entry_count) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] reply %0d: exp status=%0d score=%h tag=%h count=%0d, ",
                     $realtime, reply_cnt, want.status, want.top_score, want.top_payload,
                     want.entry_count,
                     "got status=%0d score=%h tag=%h count=%0d",
                     rsp_o.status, rsp_o.top_score, rsp_o.top_payload, rsp_o.entry_count);
        end
      end
    end
  end

  // Hard stop in case the queue hangs.
  initial begin
    #20_000_000;
    $display("Run limit reached with %0d replies outstanding.", heap_replies_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned waited;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_heap();
    test_extremes_and_order();
    test_full_heap();
    test_random_mix(480);
    calm_tail = 1'b1;
    test_random_mix(80);

    req_valid_i <= 1'b0;
    waited = 0;
    while (heap_replies_q.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (heap_replies_q.size() != 0) begin
      mismatch_cnt++;
      $display("%0d predicted replies never arrived.", heap_replies_q.size());
    end

    $display("Covered %0d inserts, %0d extracts, %0d peeks over %0d replies, peak fill %0d.",
             n_insert, n_extract, n_peek, reply_cnt, peak_fill);
    $display("Saw %0d full drops, %0d empty reads, %0d ignored scores; %0d mismatches.",
             n_full, n_empty, n_ignored, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
